>>> rtl/core/smx_pkg.sv
`default_nettype none

package smx_pkg;

  localparam int DATA_W     = 32;
  localparam int IDX_W      = 3;
  localparam int OPC_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  // Wide enough for a dimension of up to sixteen.
  localparam int DIM_W      = 5;
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = 1;
  localparam int CMDQ_CNT_W = 2;

  typedef enum logic [OPC_W-1:0] {
    OPC_LOAD_A = 3'd0,
    OPC_LOAD_B = 3'd1,
    OPC_ADD    = 3'd2,
    OPC_MUL    = 3'd3,
    OPC_TRANS  = 3'd4
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_A_ROWS = 2'd0,
    CFG_A_COLS = 2'd1,
    CFG_B_ROWS = 2'd2,
    CFG_B_COLS = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_LOAD_A,
    CMD_LOAD_B,
    CMD_ADD,
    CMD_MUL,
    CMD_TRANS,
    CMD_ERR
  } cmd_op_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ISSUE,
    BK_DRAIN
  } bk_state_e;

  typedef struct packed {
    cmd_op_e                  op;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [DATA_W-1:0] element;
    logic [DIM_W-1:0]         rr;
    logic [DIM_W-1:0]         rc;
    logic [DIM_W-1:0]         kn;
  } cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/smx_front.sv
`default_nettype none

module smx_front #(
  parameter int MAX_DIM = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [smx_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [smx_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            push_i,
  input  logic [smx_pkg::OPC_W-1:0]       opcode_i,
  input  logic [smx_pkg::IDX_W-1:0]       row_index_i,
  input  logic [smx_pkg::IDX_W-1:0]       col_index_i,
  input  logic signed [smx_pkg::DATA_W-1:0] element_i,
  input  logic                            q_full_i,
  output logic                            q_push_o,
  output smx_pkg::cmd_t                   cmd_o
);
  import smx_pkg::*;

  logic [CFG_DATA_W-1:0] a_rows_q, a_rows_d, a_cols_q, a_cols_d;
  logic [CFG_DATA_W-1:0] b_rows_q, b_rows_d, b_cols_q, b_cols_d;
  logic [DIM_W-1:0]      ar, ac, br, bc;
  logic                  in_range;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
    if (DIM_W'(v) > DIM_W'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end
    return DIM_W'(v);
  endfunction

  assign cfg_ready_o = 1'b1;

  always_comb begin
    a_rows_d = a_rows_q;
    a_cols_d = a_cols_q;
    b_rows_d = b_rows_q;
    b_cols_d = b_cols_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_A_ROWS: a_rows_d = cfg_data_i;
        CFG_A_COLS: a_cols_d = cfg_data_i;
        CFG_B_ROWS: b_rows_d = cfg_data_i;
        CFG_B_COLS: b_cols_d = cfg_data_i;
        default:    a_rows_d = a_rows_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_rows_q <= '0;
      a_cols_q <= '0;
      b_rows_q <= '0;
      b_cols_q <= '0;
    end else begin
      a_rows_q <= a_rows_d;
      a_cols_q <= a_cols_d;
      b_rows_q <= b_rows_d;
      b_cols_q <= b_cols_d;
    end
  end

  assign ar = clamp_dim(a_rows_q);
  assign ac = clamp_dim(a_cols_q);
  assign br = clamp_dim(b_rows_q);
  assign bc = clamp_dim(b_cols_q);

  assign in_range = (DIM_W'(row_index_i) < DIM_W'(MAX_DIM)) &&
                    (DIM_W'(col_index_i) < DIM_W'(MAX_DIM));

  assign q_push_o = push_i && !q_full_i;

  always_comb begin
    cmd_o         = '0;
    cmd_o.op      = CMD_NOP;
    cmd_o.row     = row_index_i;
    cmd_o.col     = col_index_i;
    cmd_o.element = element_i;
    unique case (opcode_i) inside
      OPC_LOAD_A, OPC_LOAD_B: begin
        if (in_range) begin
          cmd_o.op = (opcode_i == OPC_LOAD_A) ? CMD_LOAD_A : CMD_LOAD_B;
        end
      end
      OPC_ADD: begin
        if (ar != br || ac != bc) begin
          cmd_o.op = CMD_ERR;
        end else begin
          cmd_o.rr = ar;
          cmd_o.rc = ac;
          cmd_o.op = (ar == '0 || ac == '0) ? CMD_NOP : CMD_ADD;
        end
      end
      OPC_MUL: begin
        if (ac != br) begin
          cmd_o.op = CMD_ERR;
        end else begin
          cmd_o.rr = ar;
          cmd_o.rc = bc;
          cmd_o.kn = ac;
          cmd_o.op = (ar == '0 || bc == '0) ? CMD_NOP : CMD_MUL;
        end
      end
      OPC_TRANS: begin
        cmd_o.rr = ac;
        cmd_o.rc = ar;
        cmd_o.op = (ac == '0 || ar == '0) ? CMD_NOP : CMD_TRANS;
      end
      default: cmd_o.op = CMD_NOP;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/smx_cmd_fifo.sv
`default_nettype none

module smx_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  smx_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output smx_pkg::cmd_t data_o
);
  import smx_pkg::*;

  cmd_t                  entry_q [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CMDQ_CNT_W-1:0] cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign full_o  = (cnt_q == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/smx_back.sv
`default_nettype none

module smx_back #(
  parameter int MAX_DIM = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cmd_valid_i,
  input  smx_pkg::cmd_t                     cmd_i,
  output logic                              cmd_pop_o,
  input  logic                              pop_i,
  output logic                              empty_o,
  output logic signed [smx_pkg::DATA_W-1:0] result_value_o,
  output logic [smx_pkg::IDX_W-1:0]         result_row_o,
  output logic [smx_pkg::IDX_W-1:0]         result_col_o,
  output logic                              last_o,
  output logic                              size_error_o
);
  import smx_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DATA_W-1:0] mem_a [DEPTH];
  logic [DATA_W-1:0] mem_b [DEPTH];

  bk_state_e         state_q, state_d;
  cmd_t              cmd_q, cmd_d;
  logic [DIM_W-1:0]  i_q, i_d, j_q, j_d, k_q, k_d;
  logic              rd_vld_q, rd_vld_d, prod_vld_q, prod_vld_d;
  logic [DATA_W-1:0] rd_a_q, rd_b_q, prod_q, prod_d, acc_q, acc_d;
  logic              out_vld_q, out_vld_d;
  logic [DATA_W-1:0] res_value_q, res_value_d;
  logic [IDX_W-1:0]  res_row_q, res_row_d, res_col_q, res_col_d;
  logic              res_last_q, res_last_d, res_err_q, res_err_d;

  logic              out_free, rd_en, wr_a, wr_b, acc_clr, elem_last, pipe_empty;
  logic [AW-1:0]     a_raddr, b_raddr, waddr;
  logic [DATA_W-1:0] elem_value;

  function automatic logic [AW-1:0] cell_addr(input logic [DIM_W-1:0] r,
                                              input logic [DIM_W-1:0] c);
    return AW'(r) * AW'(MAX_DIM) + AW'(c);
  endfunction

  assign out_free   = !out_vld_q || pop_i;
  assign pipe_empty = !rd_vld_q && !prod_vld_q;
  assign waddr      = cell_addr(DIM_W'(cmd_i.row), DIM_W'(cmd_i.col));
  assign elem_last  = (i_q + DIM_W'(1) == cmd_q.rr) && (j_q + DIM_W'(1) == cmd_q.rc);

  always_comb begin
    a_raddr = cell_addr(i_q, j_q);
    b_raddr = cell_addr(i_q, j_q);
    if (cmd_q.op == CMD_MUL) begin
      a_raddr = cell_addr(i_q, k_q);
      b_raddr = cell_addr(k_q, j_q);
    end else if (cmd_q.op == CMD_TRANS) begin
      a_raddr = cell_addr(j_q, i_q);
    end
  end

  always_comb begin
    case (cmd_q.op)
      CMD_MUL: elem_value = acc_q;
      CMD_ADD: elem_value = rd_a_q + rd_b_q;
      default: elem_value = rd_a_q;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    cmd_pop_o   = 1'b0;
    wr_a        = 1'b0;
    wr_b        = 1'b0;
    rd_en       = 1'b0;
    acc_clr     = 1'b0;
    out_vld_d   = out_vld_q && !pop_i;
    res_value_d = res_value_q;
    res_row_d   = res_row_q;
    res_col_d   = res_col_q;
    res_last_d  = res_last_q;
    res_err_d   = res_err_q;

    unique case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op) inside
            CMD_LOAD_A: begin
              cmd_pop_o = 1'b1;
              wr_a      = 1'b1;
            end
            CMD_LOAD_B: begin
              cmd_pop_o = 1'b1;
              wr_b      = 1'b1;
            end
            CMD_ERR: begin
              if (out_free) begin
                cmd_pop_o   = 1'b1;
                out_vld_d   = 1'b1;
                res_value_d = '0;
                res_row_d   = '0;
                res_col_d   = '0;
                res_last_d  = 1'b1;
                res_err_d   = 1'b1;
              end
            end
            CMD_ADD, CMD_MUL, CMD_TRANS: begin
              cmd_pop_o = 1'b1;
              cmd_d     = cmd_i;
              i_d       = '0;
              j_d       = '0;
              k_d       = '0;
              acc_clr   = 1'b1;
              state_d   = BK_ISSUE;
            end
            default: cmd_pop_o = 1'b1;
          endcase
        end
      end
      BK_ISSUE: begin
        rd_en = (cmd_q.op != CMD_MUL) || (k_q < cmd_q.kn);
        if (cmd_q.op == CMD_MUL && (k_q + DIM_W'(1) < cmd_q.kn)) begin
          k_d = k_q + DIM_W'(1);
        end else begin
          state_d = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        if (pipe_empty && out_free) begin
          out_vld_d   = 1'b1;
          res_value_d = elem_value;
          res_row_d   = i_q[IDX_W-1:0];
          res_col_d   = j_q[IDX_W-1:0];
          res_last_d  = elem_last;
          res_err_d   = 1'b0;
          if (elem_last) begin
            state_d = BK_IDLE;
          end else begin
            if (j_q + DIM_W'(1) < cmd_q.rc) begin
              j_d = j_q + DIM_W'(1);
            end else begin
              j_d = '0;
              i_d = i_q + DIM_W'(1);
            end
            k_d     = '0;
            acc_clr = 1'b1;
            state_d = BK_ISSUE;
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  assign rd_vld_d   = rd_en;
  assign prod_vld_d = rd_vld_q;
  assign prod_d     = rd_a_q * rd_b_q;
  assign acc_d      = acc_clr ? '0 : (prod_vld_q ? acc_q + prod_q : acc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BK_IDLE;
      i_q        <= '0;
      j_q        <= '0;
      k_q        <= '0;
      rd_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      i_q        <= i_d;
      j_q        <= j_d;
      k_q        <= k_d;
      rd_vld_q   <= rd_vld_d;
      prod_vld_q <= prod_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    prod_q      <= prod_d;
    acc_q       <= acc_d;
    res_value_q <= res_value_d;
    res_row_q   <= res_row_d;
    res_col_q   <= res_col_d;
    res_last_q  <= res_last_d;
    res_err_q   <= res_err_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      mem_a[waddr] <= cmd_i.element;
    end
    if (wr_b) begin
      mem_b[waddr] <= cmd_i.element;
    end
    if (rd_en) begin
      rd_a_q <= mem_a[a_raddr];
      rd_b_q <= mem_b[b_raddr];
    end
  end

  assign empty_o        = !out_vld_q;
  assign result_value_o = res_value_q;
  assign result_row_o   = res_row_q;
  assign result_col_o   = res_col_q;
  assign last_o         = res_last_q;
  assign size_error_o   = res_err_q;

  a_rd_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == BK_ISSUE || state_q == BK_DRAIN))
    else $error("read data returned outside an element walk");

  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_err_q |-> res_last_q && res_value_q == '0 &&
                               res_row_q == '0 && res_col_q == '0)
    else $error("size error beat is not a lone zero beat");

  a_walk_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_ISSUE |-> i_q < cmd_q.rr && j_q < cmd_q.rc)
    else $error("element walk left the result matrix");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !pop_i |=> out_vld_q)
    else $error("waiting result dropped without being taken");

endmodule

`default_nettype wire

>>> rtl/core/small_matrix_engine.sv
// Matrix engine holding two integer matrices A and B of up to MAX_DIM by MAX_DIM.
// Sizes are set through the configuration channel (cfg_valid_i / cfg_ready_o),
// which is always ready; sizes above MAX_DIM are treated as MAX_DIM.
// Items enter through push / full. Loads write one element of A or B; add,
// multiply and transpose commands stream the result matrix row by row, and each
// result beat leaves through empty / pop with the final beat of a command marked.
// A size mismatch gives a single beat flagged as an error.
// A two-entry command queue parts the input side from the execution side, so
// items are taken while earlier commands still run or results wait to be popped.
// Result elements are worked out one at a time. A multiply result is built by
// the read, multiply and accumulate steps of the dot product over the inner
// dimension, through the single read port of each matrix store.
// Reset clears the sizes to zero and empties the queue and the result register;
// matrix contents are undefined until loaded.
// While the receiver does not pop, the waiting beat holds, execution pauses, the
// queue fills and full rises.
`default_nettype none

module small_matrix_engine #(
  parameter int MAX_DIM = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [smx_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [smx_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              push,
  output logic                              full,
  input  logic [smx_pkg::OPC_W-1:0]         opcode_i,
  input  logic [smx_pkg::IDX_W-1:0]         row_index_i,
  input  logic [smx_pkg::IDX_W-1:0]         col_index_i,
  input  logic signed [smx_pkg::DATA_W-1:0] element_i,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [smx_pkg::DATA_W-1:0] result_value_o,
  output logic [smx_pkg::IDX_W-1:0]         result_row_o,
  output logic [smx_pkg::IDX_W-1:0]         result_col_o,
  output logic                              last_o,
  output logic                              size_error_o
);
  import smx_pkg::*;

  cmd_t front_cmd, q_cmd;
  logic q_push, q_full, q_valid, q_pop;

  assign full = q_full;

  smx_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_i      (push),
    .opcode_i    (opcode_i),
    .row_index_i (row_index_i),
    .col_index_i (col_index_i),
    .element_i   (element_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .cmd_o       (front_cmd)
  );

  smx_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (front_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_cmd)
  );

  smx_back #(
    .MAX_DIM(MAX_DIM)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (q_valid),
    .cmd_i          (q_cmd),
    .cmd_pop_o      (q_pop),
    .pop_i          (pop),
    .empty_o        (empty),
    .result_value_o (result_value_o),
    .result_row_o   (result_row_o),
    .result_col_o   (result_col_o),
    .last_o         (last_o),
    .size_error_o   (size_error_o)
  );

endmodule

`default_nettype wire

>>> tb/small_matrix_engine_checker.sv
`timescale 1ns / 100ps

module small_matrix_engine_checker
  import smx_pkg::*;
#(
  parameter int MAX_DIM = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   push_i,
  input  logic                   full_i,
  input  logic [OPC_W-1:0]       opcode_i,
  input  logic [IDX_W-1:0]       row_index_i,
  input  logic [IDX_W-1:0]       col_index_i,
  input  logic [DATA_W-1:0]      element_i,
  input  logic                   empty_i,
  input  logic                   pop_i,
  input  logic [DATA_W-1:0]      result_value_i,
  input  logic [IDX_W-1:0]       result_row_i,
  input  logic [IDX_W-1:0]       result_col_i,
  input  logic                   last_i,
  input  logic                   size_error_i,
  input  logic                   end_check_i,
  output int                     outstanding_o,
  output int                     errors_o
);

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic              last;
    logic              size_error;
  } beat_t;

  beat_t             expected_beats[$];
  logic [DATA_W-1:0] mat_a [MAX_DIM*MAX_DIM];
  logic [DATA_W-1:0] mat_b [MAX_DIM*MAX_DIM];
  logic [CFG_DATA_W-1:0] a_rows, a_cols, b_rows, b_cols;
  int errors = 0;
  bit end_done = 1'b0;

  initial begin
    outstanding_o = 0;
    errors_o = 0;
    a_rows = '0;
    a_cols = '0;
    b_rows = '0;
    b_cols = '0;
    for (int n = 0; n < MAX_DIM * MAX_DIM; n++) begin
      mat_a[n] = '0;
      mat_b[n] = '0;
    end
  end

  function automatic int used_dim(input logic [CFG_DATA_W-1:0] v);
    return (int'(v) > MAX_DIM) ? MAX_DIM : int'(v);
  endfunction

  task automatic report(input string msg);
    errors++;
    if (errors <= 100) begin
      $display("[%0t] %s", $time, msg);
    end
  endtask

  task automatic check_field(input string name, input logic [DATA_W-1:0] got,
                             input logic [DATA_W-1:0] want);
    if (got !== want) begin
      report($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  task automatic predict_matrix_op(input logic [OPC_W-1:0] op, input logic [IDX_W-1:0] r,
                                   input logic [IDX_W-1:0] c, input logic [DATA_W-1:0] v);
    int ar, ac, br, bc, nr, nc;
    logic [DATA_W-1:0] acc;
    ar = used_dim(a_rows);
    ac = used_dim(a_cols);
    br = used_dim(b_rows);
    bc = used_dim(b_cols);
    case (op)
      OPC_LOAD_A: mat_a[r * MAX_DIM + c] = v;
      OPC_LOAD_B: mat_b[r * MAX_DIM + c] = v;
      OPC_ADD, OPC_MUL, OPC_TRANS: begin
        if ((op == OPC_ADD && (ar != br || ac != bc)) || (op == OPC_MUL && ac != br)) begin
          expected_beats.push_back(beat_t'{value: '0, row: '0, col: '0, last: 1'b1,
                                           size_error: 1'b1});
        end else begin
          nr = (op == OPC_TRANS) ? ac : ar;
          nc = (op == OPC_ADD) ? ac : ((op == OPC_MUL) ? bc : ar);
          for (int i = 0; i < nr; i++) begin
            for (int j = 0; j < nc; j++) begin
              case (op)
                OPC_ADD: acc = mat_a[i * MAX_DIM + j] + mat_b[i * MAX_DIM + j];
                OPC_MUL: begin
                  acc = '0;
                  for (int k = 0; k < ac; k++) begin
                    acc += mat_a[i * MAX_DIM + k] * mat_b[k * MAX_DIM + j];
                  end
                end
                default: acc = mat_a[j * MAX_DIM + i];
              endcase
              expected_beats.push_back(beat_t'{value: acc, row: IDX_W'(i), col: IDX_W'(j),
                                               last: (i == nr - 1 && j == nc - 1),
                                               size_error: 1'b0});
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin
    beat_t want;
    if (!rst_ni) begin
      expected_beats.delete();
      a_rows = '0;
      a_cols = '0;
      b_rows = '0;
      b_cols = '0;
    end else begin
      if (pop_i && !empty_i) begin
        if (expected_beats.size() == 0) begin
          report($sformatf("unexpected beat: value %0h row %0d col %0d", result_value_i,
                           result_row_i, result_col_i));
        end else begin
          want = expected_beats.pop_front();
          check_field("result_value", result_value_i, want.value);
          check_field("result_row", result_row_i, want.row);
          check_field("result_col", result_col_i, want.col);
          check_field("last", last_i, want.last);
          check_field("size_error", size_error_i, want.size_error);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_A_ROWS: a_rows = cfg_data_i;
          CFG_A_COLS: a_cols = cfg_data_i;
          CFG_B_ROWS: b_rows = cfg_data_i;
          CFG_B_COLS: b_cols = cfg_data_i;
          default: ;
        endcase
      end
      if (push_i && !full_i) begin
        predict_matrix_op(opcode_i, row_index_i, col_index_i, element_i);
      end
      if (end_check_i && !end_done) begin
        end_done = 1'b1;
        if (expected_beats.size() != 0) begin
          report($sformatf("%0d expected beats never arrived", expected_beats.size()));
        end
      end
    end
    outstanding_o <= expected_beats.size();
    errors_o <= errors;
  end

endmodule

>>> tb/tb_small_matrix_engine.sv
`timescale 1ns / 100ps

module tb_small_matrix_engine;
  import smx_pkg::*;

  localparam int MAX_DIM = 8;
  localparam int SETTLE_CYCLES = 32;
  localparam int IDLE_PCT = 57;
  localparam int BOTH_PCT = 36;
  localparam logic [OPC_W-1:0] OPC_SPARE = 3'd5;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_reg_e cfg_index = CFG_A_ROWS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic push = 1'b0;
  logic full;
  logic [OPC_W-1:0] opcode = '0;
  logic [IDX_W-1:0] row_index = '0;
  logic [IDX_W-1:0] col_index = '0;
  logic signed [DATA_W-1:0] element = '0;
  logic empty;
  logic pop = 1'b0;
  logic signed [DATA_W-1:0] result_value;
  logic [IDX_W-1:0] result_row;
  logic [IDX_W-1:0] result_col;
  logic last;
  logic size_error;
  logic end_check = 1'b0;
  int outstanding;
  int errors;

  int idle_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;
  int dim_ar, dim_ac, dim_br, dim_bc;
  bit a_loaded [MAX_DIM*MAX_DIM];
  bit b_loaded [MAX_DIM*MAX_DIM];

  always #5 clk = ~clk;

  small_matrix_engine #(
    .MAX_DIM(MAX_DIM)
  ) u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .push          (push),
    .full          (full),
    .opcode_i      (opcode),
    .row_index_i   (row_index),
    .col_index_i   (col_index),
    .element_i     (element),
    .empty         (empty),
    .pop           (pop),
    .result_value_o(result_value),
    .result_row_o  (result_row),
    .result_col_o  (result_col),
    .last_o        (last),
    .size_error_o  (size_error)
  );

  small_matrix_engine_checker #(
    .MAX_DIM(MAX_DIM)
  ) u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .push_i        (push),
    .full_i        (full),
    .opcode_i      (opcode),
    .row_index_i   (row_index),
    .col_index_i   (col_index),
    .element_i     (element),
    .empty_i       (empty),
    .pop_i         (pop),
    .result_value_i(result_value),
    .result_row_i  (result_row),
    .result_col_i  (result_col),
    .last_i        (last),
    .size_error_i  (size_error),
    .end_check_i   (end_check),
    .outstanding_o (outstanding),
    .errors_o      (errors)
  );

  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= stall_pct);
  end

  function automatic int used_dim(input int v);
    return (v > MAX_DIM) ? MAX_DIM : v;
  endfunction

  function automatic logic [DATA_W-1:0] random_word();
    if ($urandom_range(99) < 15) begin
      case ($urandom_range(4))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'h0000_0000;
        3: return 32'hffff_ffff;
        default: return 32'h0000_0001;
      endcase
    end
    return $urandom;
  endfunction

  task automatic send_item(input logic [OPC_W-1:0] op, input logic [IDX_W-1:0] r,
                           input logic [IDX_W-1:0] c, input logic [DATA_W-1:0] v);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    push <= 1'b1;
    opcode <= op;
    row_index <= r;
    col_index <= c;
    element <= v;
    do @(posedge clk); while (full);
    items_sent++;
  endtask

  task automatic drain();
    push <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_dims(input int ar, input int ac, input int br, input int bc);
    write_reg(CFG_A_ROWS, CFG_DATA_W'(ar));
    write_reg(CFG_A_COLS, CFG_DATA_W'(ac));
    write_reg(CFG_B_ROWS, CFG_DATA_W'(br));
    write_reg(CFG_B_COLS, CFG_DATA_W'(bc));
    cfg_valid <= 1'b0;
    dim_ar = used_dim(ar);
    dim_ac = used_dim(ac);
    dim_br = used_dim(br);
    dim_bc = used_dim(bc);
  endtask

  task automatic load_element(input bit into_b, input int r, input int c,
                              input logic [DATA_W-1:0] v);
    if (into_b) begin
      b_loaded[r * MAX_DIM + c] = 1'b1;
      send_item(OPC_LOAD_B, IDX_W'(r), IDX_W'(c), v);
    end else begin
      a_loaded[r * MAX_DIM + c] = 1'b1;
      send_item(OPC_LOAD_A, IDX_W'(r), IDX_W'(c), v);
    end
  endtask

  task automatic fill_region(input bit into_b, input int rows, input int cols);
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        if (!(into_b ? b_loaded[r * MAX_DIM + c] : a_loaded[r * MAX_DIM + c])) begin
          load_element(into_b, r, c, random_word());
        end
      end
    end
  endtask

  // Every element that a command will read is loaded first.
  task automatic issue_command(input opcode_e op);
    case (op)
      OPC_ADD: begin
        if (dim_ar == dim_br && dim_ac == dim_bc) begin
          fill_region(1'b0, dim_ar, dim_ac);
          fill_region(1'b1, dim_br, dim_bc);
        end
      end
      OPC_MUL: begin
        if (dim_ac == dim_br) begin
          fill_region(1'b0, dim_ar, dim_ac);
          fill_region(1'b1, dim_br, dim_bc);
        end
      end
      default: fill_region(1'b0, dim_ar, dim_ac);
    endcase
    send_item(op, IDX_W'($urandom), IDX_W'($urandom), random_word());
  endtask

  task automatic random_phase(input int count);
    int start_count;
    int pick;
    opcode_e op;
    start_count = items_sent;
    while (items_sent - start_count < count) begin
      pick = $urandom_range(99);
      if (pick < 2) begin
        drain();
      end
      if (pick < 50) begin
        load_element($urandom_range(1), $urandom_range(MAX_DIM - 1),
                     $urandom_range(MAX_DIM - 1), random_word());
      end else if (pick < 92) begin
        case ($urandom_range(2))
          0: op = OPC_ADD;
          1: op = OPC_MUL;
          default: op = OPC_TRANS;
        endcase
        issue_command(op);
      end else begin
        send_item(OPC_SPARE + OPC_W'($urandom_range(2)), IDX_W'($urandom),
                  IDX_W'($urandom), random_word());
      end
    end
  endtask

  initial begin
    int mode, k;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_dims(2, 2, 2, 2);
    load_element(1'b0, 0, 0, 32'h7fff_ffff);
    load_element(1'b0, 0, 1, 32'h8000_0000);
    load_element(1'b0, 1, 0, 32'hffff_ffff);
    load_element(1'b0, 1, 1, 32'h0000_0000);
    load_element(1'b1, 0, 0, 32'h7fff_ffff);
    load_element(1'b1, 0, 1, 32'h8000_0000);
    load_element(1'b1, 1, 0, 32'h0000_0001);
    load_element(1'b1, 1, 1, 32'hffff_ffff);
    load_element(1'b0, MAX_DIM - 1, MAX_DIM - 1, 32'h5555_aaaa);
    load_element(1'b1, MAX_DIM - 1, MAX_DIM - 1, 32'haaaa_5555);
    issue_command(OPC_ADD);
    issue_command(OPC_MUL);
    issue_command(OPC_TRANS);
    send_item(OPC_SPARE, '0, '0, 32'h0);
    send_item(OPC_SPARE + 3'd1, '1, '1, 32'hffff_ffff);
    send_item(OPC_SPARE + 3'd2, '0, '1, 32'h1234_5678);
    drain();
    set_dims(0, 0, 0, 0);
    issue_command(OPC_ADD);
    issue_command(OPC_MUL);
    issue_command(OPC_TRANS);
    drain();
    set_dims(2, 0, 0, 3);
    issue_command(OPC_MUL);
    issue_command(OPC_ADD);
    issue_command(OPC_TRANS);

    for (int p = 0; p < 16; p++) begin
      drain();
      case (p / 4)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = IDLE_PCT;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = IDLE_PCT;
        end
        default: begin
          idle_pct = BOTH_PCT;
          stall_pct = BOTH_PCT;
        end
      endcase
      if (p % 4 == 3) begin
        if (p == 3) begin
          set_dims(15, 15, 15, 15);
        end else begin
          set_dims($urandom_range(MAX_DIM, 15), $urandom_range(MAX_DIM, 15),
                   $urandom_range(MAX_DIM, 15), $urandom_range(MAX_DIM, 15));
        end
        random_phase(12);
      end else begin
        mode = $urandom_range(99);
        if (mode < 40) begin
          k = $urandom_range(1, 4);
          set_dims(k, k, k, k);
        end else if (mode < 70) begin
          k = $urandom_range(1, 5);
          set_dims($urandom_range(1, 5), k, k, $urandom_range(1, 5));
        end else begin
          set_dims($urandom_range(MAX_DIM), $urandom_range(MAX_DIM),
                   $urandom_range(MAX_DIM), $urandom_range(MAX_DIM));
        end
        random_phase(33);
      end
    end

    drain();
    end_check <= 1'b1;
    repeat (2) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
